// ===== rtl/lacts_pkg.sv =====
// Shared types and constants for the link acknowledge and timeout supervisor.
package lacts_pkg;

   localparam int CMD_W      = 4;
   localparam int VALUE_W    = 15;
   localparam int NUM_W      = 15;
   localparam int STATUS_W   = 2;
   localparam int MAXU_W     = 15;
   localparam int TOUT_W     = 14;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 15;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 40;

   localparam logic [MAXU_W-1:0] MAX_UNACKED_RST = 15'd12;
   localparam logic [TOUT_W-1:0] TIMEOUT_RST     = 14'd15;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MAX_UNACKED = 4'd0,
      CSR_TIMEOUT     = 4'd1
   } lacts_csr_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK     = 4'd0,
      CMD_SENT     = 4'd1,
      CMD_RECEIVED = 4'd2,
      CMD_PEER_ACK = 4'd3,
      CMD_LOCAL_ACK = 4'd4,
      CMD_CHECK    = 4'd5,
      CMD_CLEAR    = 4'd6,
      CMD_SET_SEND = 4'd7,
      CMD_SET_RECV = 4'd8,
      CMD_TOUCH    = 4'd9
   } lacts_cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      SEND_NORMAL     = 2'd0,
      SEND_OVERRUN    = 2'd1,
      SEND_T1_EXPIRED = 2'd2
   } lacts_send_status_type;

   typedef enum logic [STATUS_W-1:0] {
      RECV_NORMAL   = 2'd0,
      RECV_OVERRUN  = 2'd1,
      RECV_ACK_DUE  = 2'd2,
      RECV_TEST_DUE = 2'd3
   } lacts_recv_status_type;

   typedef struct packed {
      logic [MAXU_W-1:0] max_unacked;
      logic [TOUT_W-1:0] timeout_seconds;
   } lacts_cfg_type;

   typedef struct packed {
      lacts_send_status_type send_status;
      lacts_recv_status_type recv_status;
      logic [NUM_W-1:0]      send_number;
      logic [NUM_W-1:0]      recv_number;
   } lacts_result_type;

endpackage

// ===== rtl/lacts_state.sv =====
// Link state registers with next-state and status logic for one command.
module lacts_state import lacts_pkg::*; #(
   parameter int SEQ_BITS   = 15,
   parameter int TIMER_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  lacts_cmd_type    cmd,
   input  logic [VALUE_W-1:0] value,
   input  lacts_cfg_type    cfg,
   output lacts_result_type result
);

   localparam int CMP_BITS = (TIMER_BITS > 16) ? TIMER_BITS : 16;

   logic [SEQ_BITS-1:0]   send_seq_ff, send_seq_in;
   logic [SEQ_BITS-1:0]   recv_seq_ff, recv_seq_in;
   logic [SEQ_BITS-1:0]   peer_acked_ff, peer_acked_in;
   logic [SEQ_BITS-1:0]   local_acked_ff, local_acked_in;
   logic [TIMER_BITS-1:0] since_send_ff, since_send_in;
   logic [TIMER_BITS-1:0] since_recv_ff, since_recv_in;
   logic [TIMER_BITS-1:0] since_test_ff, since_test_pre, since_test_in;
   logic                  link_started_ff, link_started_in;

   logic [SEQ_BITS-1:0]   val_seq;
   logic [SEQ_BITS-1:0]   s_un, r_un;
   logic [CMP_BITS-1:0]   t1, t2, t3, t3h;
   logic [CMP_BITS-1:0]   send_age, recv_age, test_age;
   logic                  test_due;

   assign val_seq = value[SEQ_BITS-1:0];

   always_comb begin
      send_seq_in     = send_seq_ff;
      recv_seq_in     = recv_seq_ff;
      peer_acked_in   = peer_acked_ff;
      local_acked_in  = local_acked_ff;
      since_send_in   = since_send_ff;
      since_recv_in   = since_recv_ff;
      since_test_pre  = since_test_ff;
      link_started_in = link_started_ff;
      case (cmd)
         CMD_TICK: begin
            if (since_send_ff != '1) since_send_in = since_send_ff + 1'b1;
            if (since_recv_ff != '1) since_recv_in = since_recv_ff + 1'b1;
            if (since_test_ff != '1) since_test_pre = since_test_ff + 1'b1;
         end
         CMD_SENT: begin
            since_send_in = '0;
            send_seq_in   = send_seq_ff + 1'b1;
         end
         CMD_RECEIVED: begin
            since_recv_in   = '0;
            recv_seq_in     = recv_seq_ff + 1'b1;
            link_started_in = 1'b1;
         end
         CMD_PEER_ACK:  peer_acked_in = val_seq;
         CMD_LOCAL_ACK: local_acked_in = val_seq;
         CMD_CLEAR: begin
            send_seq_in     = '0;
            recv_seq_in     = '0;
            peer_acked_in   = '0;
            local_acked_in  = '0;
            since_send_in   = '1;
            since_recv_in   = '1;
            link_started_in = 1'b0;
         end
         CMD_SET_SEND: send_seq_in = val_seq;
         CMD_SET_RECV: recv_seq_in = val_seq;
         CMD_TOUCH: begin
            since_recv_in   = '0;
            link_started_in = 1'b1;
         end
         default: ;
      endcase
   end

   assign t1  = CMP_BITS'(cfg.timeout_seconds);
   assign t2  = t1 >> 1;
   assign t3  = t1 + (t1 << 1);
   assign t3h = t3 >> 1;

   assign send_age = CMP_BITS'(since_send_in);
   assign recv_age = CMP_BITS'(since_recv_in);
   assign test_age = CMP_BITS'(since_test_pre);

   assign s_un = send_seq_in - peer_acked_in;
   assign r_un = recv_seq_in - local_acked_in;

   always_comb begin
      result.send_number = NUM_W'(send_seq_in);
      result.recv_number = NUM_W'(recv_seq_in);
      test_due = 1'b0;
      if (MAXU_W'(s_un) > cfg.max_unacked) begin
         result.send_status = SEND_OVERRUN;
      end else if ((s_un != '0) && (send_age > t1)) begin
         result.send_status = SEND_T1_EXPIRED;
      end else begin
         result.send_status = SEND_NORMAL;
      end
      if (MAXU_W'(r_un) > cfg.max_unacked) begin
         result.recv_status = RECV_OVERRUN;
      end else if ((r_un != '0) && (recv_age > t2)) begin
         result.recv_status = RECV_ACK_DUE;
      end else if ((r_un == '0) && (s_un == '0) && link_started_in &&
                   (recv_age > t3) && (test_age > t3h)) begin
         result.recv_status = RECV_TEST_DUE;
         test_due = 1'b1;
      end else begin
         result.recv_status = RECV_NORMAL;
      end
      since_test_in = (test_due && (cmd == CMD_CHECK)) ? '0 : since_test_pre;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         send_seq_ff     <= '0;
         recv_seq_ff     <= '0;
         peer_acked_ff   <= '0;
         local_acked_ff  <= '0;
         since_send_ff   <= '1;
         since_recv_ff   <= '1;
         since_test_ff   <= '1;
         link_started_ff <= 1'b0;
      end else if (step) begin
         send_seq_ff     <= send_seq_in;
         recv_seq_ff     <= recv_seq_in;
         peer_acked_ff   <= peer_acked_in;
         local_acked_ff  <= local_acked_in;
         since_send_ff   <= since_send_in;
         since_recv_ff   <= since_recv_in;
         since_test_ff   <= since_test_in;
         link_started_ff <= link_started_in;
      end
   end

   a_clear_resets: assert property (@(posedge clock) disable iff (reset)
      (step && (cmd == CMD_CLEAR)) |=>
         (send_seq_ff == '0) && (recv_seq_ff == '0) && !link_started_ff)
      else $error("Clear did not reset the sequence state.");

   a_test_needs_link: assert property (@(posedge clock) disable iff (reset)
      (result.recv_status == RECV_TEST_DUE) |-> link_started_in)
      else $error("Test due reported before the link started.");

   a_test_restamp: assert property (@(posedge clock) disable iff (reset)
      (step && (cmd != CMD_CHECK) && (since_test_ff != '0)) |=> (since_test_ff != '0))
      else $error("Test timer cleared by a command other than check.");

endmodule

// ===== rtl/link_ack_timeout_supervisor_core.sv =====
// Top level: input register, link state update and result register.
// A request waits in the input register until the result register can take its result.
// Throughput: one per cycle; input stalls only while a result waits untaken.
// Reset: synchronous, active high; clears counters and acknowledge marks, saturates
// the three second timers, clears link started and restores register defaults.
// Configuration writes are registered directly in the configuration register; csr_ready is always high.
module link_ack_timeout_supervisor_core import lacts_pkg::*; #(
   parameter int SEQ_BITS   = 15,
   parameter int TIMER_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // value[14:0], zero pad
   input  logic [CMD_W-1:0]      req_tuser,  // command[3:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // send_status[1:0], recv_status[3:2], send_number[18:4], recv_number[33:19]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   lacts_cfg_type      cfg_ff;
   logic               req_valid_ff;
   lacts_cmd_type      req_cmd_ff;
   logic [VALUE_W-1:0] req_value_ff;
   logic               rsp_valid_ff;
   lacts_result_type   rsp_ff;
   lacts_result_type   result;
   logic               advance;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_unacked     <= MAX_UNACKED_RST;
         cfg_ff.timeout_seconds <= TIMEOUT_RST;
      end else if (csr_valid) begin
         case (lacts_csr_type'(csr_index))
            CSR_MAX_UNACKED: cfg_ff.max_unacked <= csr_wdata[MAXU_W-1:0];
            CSR_TIMEOUT:     cfg_ff.timeout_seconds <= csr_wdata[TOUT_W-1:0];
            default: ;
         endcase
      end
   end

   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_cmd_ff   <= lacts_cmd_type'(req_tuser);
         req_value_ff <= req_tdata[VALUE_W-1:0];
      end
   end

   lacts_state #(
      .SEQ_BITS   (SEQ_BITS),
      .TIMER_BITS (TIMER_BITS)
   ) u_state (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .cmd    (req_cmd_ff),
      .value  (req_value_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ff.recv_number, rsp_ff.send_number,
                        rsp_ff.recv_status, rsp_ff.send_status};

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("Advanced transaction did not reach the result register.");

   a_stall_reason: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (req_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("Request side stalled without a blocked result.");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("Pending result changed before it was taken.");

endmodule
